### rtl/bmpp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the BMP pixel stream parser.
// No dependencies; used by bmpp_decode and bmp_pixel_stream_parser_core.

package bmpp_pkg;

    // Default for the largest accepted width/height
    localparam int MAX_DIM_DEFAULT = 4096;

    // Output field widths
    localparam int COORD_W = 12;
    localparam int KIND_W  = 3;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_PIXEL      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_BAD_MAGIC  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_BAD_RSVD   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BAD_PLANES = 3'd3;
    localparam logic [KIND_W-1:0] KIND_BAD_DEPTH  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_BAD_SIZE   = 3'd5;
    localparam logic [KIND_W-1:0] KIND_BAD_OFFSET = 3'd6;

    // Header constants
    localparam logic [15:0] BMP_MAGIC    = 16'h4D42;
    localparam logic [15:0] BMP_PLANES   = 16'd1;
    localparam logic [15:0] BMP_DEPTH    = 16'd24;
    localparam logic [31:0] HEADER_BYTES = 32'd30;

    // One decoded result
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic               last_pixel;
    } result_t;

endpackage

### rtl/bmpp_decode.sv
`timescale 1ns / 1ps
// Parser state and per-byte step logic: header checks, offset skip,
// pixel assembly and row padding. Depends on bmpp_pkg.

module bmpp_decode #(
    parameter int MAX_DIM = bmpp_pkg::MAX_DIM_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,        // consume one byte this cycle
    input  logic [7:0]         data_byte,
    input  logic               file_start,
    output logic               res_valid,
    output bmpp_pkg::result_t  res
);

    localparam int DIM_RAW = $clog2(MAX_DIM + 1);
    localparam int DIM_W   = (DIM_RAW < 2) ? 2 : DIM_RAW;

    localparam logic [2:0] PH_WAIT   = 3'd0;
    localparam logic [2:0] PH_HEADER = 3'd1;
    localparam logic [2:0] PH_SKIP   = 3'd2;
    localparam logic [2:0] PH_PIXEL  = 3'd3;
    localparam logic [2:0] PH_PAD    = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    // Header byte index of the last byte of each checked field
    localparam logic [31:0] IDX_MAGIC  = 32'd1;
    localparam logic [31:0] IDX_RSVD1  = 32'd7;
    localparam logic [31:0] IDX_RSVD2  = 32'd9;
    localparam logic [31:0] IDX_OFFSET = 32'd13;
    localparam logic [31:0] IDX_WIDTH  = 32'd21;
    localparam logic [31:0] IDX_HEIGHT = 32'd25;
    localparam logic [31:0] IDX_PLANES = 32'd27;
    localparam logic [31:0] IDX_DEPTH  = 32'd29;

    logic [2:0]       phase_reg,   phase_next;
    logic [31:0]      count_reg,   count_next;
    logic [31:0]      shift_reg,   shift_next;
    logic [31:0]      offset_reg,  offset_next;
    logic [DIM_W-1:0] width_reg,   width_next;
    logic [DIM_W-1:0] height_reg,  height_next;
    logic [DIM_W-1:0] col_reg,     col_next;
    logic [DIM_W-1:0] row_reg,     row_next;
    logic [1:0]       bip_reg,     bip_next;
    logic [7:0]       blue_reg,    blue_next;
    logic [7:0]       green_reg,   green_next;
    logic [1:0]       pad_reg,     pad_next;

    // Values after a file_start restart is applied
    logic [2:0]       ph_eff;
    logic [31:0]      cnt_eff;
    logic [31:0]      sh_eff;
    logic [31:0]      sh_new;
    logic [DIM_W-1:0] col_eff;
    logic [DIM_W-1:0] row_eff;
    logic [DIM_W-1:0] col_inc;
    logic [DIM_W-1:0] row_inc;
    logic [1:0]       bip_eff;
    logic [1:0]       pad_eff;
    logic             do_pixel;
    logic             sh_bad_dim;

    always_comb
    begin
        ph_eff  = file_start ? PH_HEADER : phase_reg;
        cnt_eff = file_start ? 32'd0 : count_reg;
        sh_eff  = file_start ? 32'd0 : shift_reg;
        col_eff = file_start ? '0 : col_reg;
        row_eff = file_start ? '0 : row_reg;
        bip_eff = file_start ? 2'd0 : bip_reg;
        pad_eff = file_start ? 2'd0 : pad_reg;

        sh_new     = {data_byte, sh_eff[31:8]};
        sh_bad_dim = (sh_new == 32'd0) || (sh_new > 32'(MAX_DIM));
        col_inc    = col_eff + 1'b1;
        row_inc    = row_eff + 1'b1;
        do_pixel   = (ph_eff == PH_PIXEL) || ((ph_eff == PH_SKIP) && (cnt_eff == offset_reg));

        phase_next  = ph_eff;
        count_next  = cnt_eff;
        shift_next  = sh_eff;
        offset_next = offset_reg;
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_eff;
        row_next    = row_eff;
        bip_next    = bip_eff;
        blue_next   = blue_reg;
        green_next  = green_reg;
        pad_next    = pad_eff;

        res_valid = 1'b0;
        res       = '0;

        if (ph_eff == PH_HEADER)
        begin
            shift_next = sh_new;
            count_next = cnt_eff + 32'd1;
            if (cnt_eff == IDX_MAGIC)
            begin
                if (sh_new[31:16] != bmpp_pkg::BMP_MAGIC)
                begin
                    res_valid = 1'b1;
                    res.kind  = bmpp_pkg::KIND_BAD_MAGIC;
                end
            end
            else if (cnt_eff == IDX_RSVD1 || cnt_eff == IDX_RSVD2)
            begin
                if (sh_new[31:16] != 16'd0)
                begin
                    res_valid = 1'b1;
                    res.kind  = bmpp_pkg::KIND_BAD_RSVD;
                end
            end
            else if (cnt_eff == IDX_OFFSET)
            begin
                offset_next = sh_new;
                if (sh_new < bmpp_pkg::HEADER_BYTES)
                begin
                    res_valid = 1'b1;
                    res.kind  = bmpp_pkg::KIND_BAD_OFFSET;
                end
            end
            else if (cnt_eff == IDX_WIDTH)
            begin
                if (sh_bad_dim)
                begin
                    res_valid = 1'b1;
                    res.kind  = bmpp_pkg::KIND_BAD_SIZE;
                end
                else
                    width_next = sh_new[DIM_W-1:0];
            end
            else if (cnt_eff == IDX_HEIGHT)
            begin
                if (sh_bad_dim)
                begin
                    res_valid = 1'b1;
                    res.kind  = bmpp_pkg::KIND_BAD_SIZE;
                end
                else
                    height_next = sh_new[DIM_W-1:0];
            end
            else if (cnt_eff == IDX_PLANES)
            begin
                if (sh_new[31:16] != bmpp_pkg::BMP_PLANES)
                begin
                    res_valid = 1'b1;
                    res.kind  = bmpp_pkg::KIND_BAD_PLANES;
                end
            end
            else if (cnt_eff == IDX_DEPTH)
            begin
                if (sh_new[31:16] != bmpp_pkg::BMP_DEPTH)
                begin
                    res_valid = 1'b1;
                    res.kind  = bmpp_pkg::KIND_BAD_DEPTH;
                end
                else
                    phase_next = (offset_reg == bmpp_pkg::HEADER_BYTES) ? PH_PIXEL : PH_SKIP;
            end
            if (res_valid)
                phase_next = PH_WAIT;
        end
        else if (do_pixel)
        begin
            phase_next = PH_PIXEL;
            if (bip_eff == 2'd0)
            begin
                blue_next = data_byte;
                bip_next  = 2'd1;
            end
            else if (bip_eff == 2'd1)
            begin
                green_next = data_byte;
                bip_next   = 2'd2;
            end
            else
            begin
                bip_next       = 2'd0;
                res_valid      = 1'b1;
                res.kind       = bmpp_pkg::KIND_PIXEL;
                res.column     = bmpp_pkg::COORD_W'(col_eff);
                res.row        = bmpp_pkg::COORD_W'(height_reg - 1'b1 - row_eff);
                res.red        = data_byte;
                res.green      = green_reg;
                res.blue       = blue_reg;
                res.last_pixel = (col_inc == width_reg) && (row_inc == height_reg);
                col_next       = col_inc;
                if (col_inc >= width_reg)
                begin
                    col_next = '0;
                    row_next = row_inc;
                    pad_next = width_reg[1:0];
                    if (row_inc >= height_reg)
                        phase_next = PH_DONE;
                    else if (width_reg[1:0] != 2'd0)
                        phase_next = PH_PAD;
                end
            end
        end
        else if (ph_eff == PH_SKIP)
            count_next = cnt_eff + 32'd1;
        else if (ph_eff == PH_PAD)
        begin
            if (pad_eff != 2'd0)
                pad_next = pad_eff - 2'd1;
            if (pad_eff <= 2'd1)
                phase_next = PH_PIXEL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_WAIT;
            count_reg  <= '0;
            shift_reg  <= '0;
            offset_reg <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            bip_reg    <= '0;
            blue_reg   <= '0;
            green_reg  <= '0;
            pad_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            shift_reg  <= shift_next;
            offset_reg <= offset_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            bip_reg    <= bip_next;
            blue_reg   <= blue_next;
            green_reg  <= green_next;
            pad_reg    <= pad_next;
        end
    end

endmodule

### rtl/bmp_pixel_stream_parser_core.sv
`timescale 1ns / 1ps
// Top level of the 24-bit BMP byte stream parser: input register, decoder,
// result register. Depends on bmpp_pkg and bmpp_decode.
//
//  Channel  | Dir | Beat carries
//  ---------+-----+-------------------------------------------------------
//  s_axis   | in  | one file byte; tuser flags the first byte of a file
//  m_axis   | out | one pixel or error code; tlast flags the image's last pixel
//
// One beat per clock sustained while m_axis_tready stays high. A byte is
// registered in the input register on accept and decoded from there into the
// result register once that register is free or being taken. Bytes that
// neither finish a pixel nor fail a header check yield no output beat. While a
// result waits for m_axis_tready the input register can still take one beat;
// s_axis_tready drops only when both are full. Reset (rst_n low, asynchronous)
// empties both stages and returns the parser to waiting for a first byte.

module bmp_pixel_stream_parser_core #(
    parameter int MAX_DIM = bmpp_pkg::MAX_DIM_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] file_start

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [11:0] column, [23:12] row, [31:24] red,
                                        // [39:32] green, [47:40] blue
    output logic [2:0]  m_axis_tuser,   // [2:0] kind
    output logic        m_axis_tlast    // last_pixel
);

    // Input stage
    logic               in_valid_reg, in_valid_next;
    logic [7:0]         in_byte_reg;
    logic               in_start_reg;

    // Output stage
    logic               out_valid_reg, out_valid_next;
    bmpp_pkg::result_t  out_res_reg;

    logic               s_accept;
    logic               advance;       // input stage moves through the decoder
    logic               dec_valid;
    bmpp_pkg::result_t  dec_res;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = dec_valid;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    bmpp_decode #(
        .MAX_DIM (MAX_DIM)
    ) u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .data_byte  (in_byte_reg),
        .file_start (in_start_reg),
        .res_valid  (dec_valid),
        .res        (dec_res)
    );

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg  <= s_axis_tdata;
            in_start_reg <= s_axis_tuser[0];
        end
        if (advance)
            out_res_reg <= dec_res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_res_reg.blue, out_res_reg.green, out_res_reg.red,
                            out_res_reg.row, out_res_reg.column};
    assign m_axis_tuser  = out_res_reg.kind;
    assign m_axis_tlast  = out_res_reg.last_pixel;

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for bmp_pixel_stream_parser_core: streams BMP files built
// on the fly and checks every pixel/error beat against an in-bench decoder.
// Depends on bmpp_pkg and the parser RTL.

module tb;

    localparam int DIM_LIMIT     = bmpp_pkg::MAX_DIM_DEFAULT;
    localparam int RANDOM_BYTES  = 150;
    localparam int HOLD_CYCLES   = 300;   // long back-pressure stretch
    localparam int HOLD_AT_BEAT  = 45;    // lands inside the wide-image directed file
    localparam int DRAIN_LIMIT   = 2000;
    localparam int TAIL_CYCLES   = 10;    // result trails its byte through the input and result registers
    localparam logic [31:0] INFO_HDR_SIZE = 32'd40;

    // Byte index of the last byte of each checked header field
    localparam logic [31:0] POS_MAGIC_END  = 32'd1;
    localparam logic [31:0] POS_RSVD1_END  = 32'd7;
    localparam logic [31:0] POS_RSVD2_END  = 32'd9;
    localparam logic [31:0] POS_OFFSET_END = 32'd13;
    localparam logic [31:0] POS_WIDTH_END  = 32'd21;
    localparam logic [31:0] POS_HEIGHT_END = 32'd25;
    localparam logic [31:0] POS_PLANES_END = 32'd27;
    localparam logic [31:0] POS_DEPTH_END  = 32'd29;

    typedef enum logic [2:0] {
        ST_WAIT, ST_HEADER, ST_SKIP, ST_PIXEL, ST_PAD, ST_DONE
    } parse_state_t;

    typedef enum int {
        FLT_NONE, FLT_MAGIC, FLT_RSVD, FLT_OFFSET, FLT_WIDTH, FLT_HEIGHT, FLT_PLANES, FLT_DEPTH
    } hdr_fault_t;

    typedef struct {
        logic [7:0] data;
        logic       first;
        int         gap;     // idle cycles before this byte is offered
        bit         drain;   // hold this byte until all expected results are in
    } file_byte_t;

    typedef struct {
        logic [15:0] magic;
        logic [15:0] rsvd1;
        logic [15:0] rsvd2;
        logic [31:0] offset;
        logic [31:0] width;
        logic [31:0] height;
        logic [15:0] planes;
        logic [15:0] depth;
    } bmp_hdr_t;

    // ------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------
    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic [0:0]  s_axis_tuser  = 1'b0;   // [0] file_start

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;           // [11:0] column, [23:12] row, [31:24] red,
                                         // [39:32] green, [47:40] blue
    logic [2:0]  m_axis_tuser;           // [2:0] kind
    logic        m_axis_tlast;           // last_pixel

    always #5 clk = ~clk;

    bmp_pixel_stream_parser_core #(
        .MAX_DIM (DIM_LIMIT)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    file_byte_t         feed_q[$];       // bytes still to be offered
    bmpp_pkg::result_t  decoded_q[$];    // decoded beats not yet seen on m_axis
    int                 errs       = 0;
    int                 bytes_sent = 0;
    int                 beats_seen = 0;
    int                 gap_max    = 0;  // sender idling for the file being built
    bit                 rx_hold    = 1'b0;
    bit                 rx_lazy    = 1'b1;

    // Decoder state (reset values)
    parse_state_t ps        = ST_WAIT;
    logic [31:0]  hdr_idx   = '0;
    logic [31:0]  hdr_shift = '0;
    logic [31:0]  px_offset = '0;
    logic [31:0]  img_w     = '0;
    logic [31:0]  img_h     = '0;
    logic [31:0]  col_n     = '0;
    logic [31:0]  row_n     = '0;
    logic [1:0]   px_byte   = '0;
    logic [1:0]   pad_n     = '0;
    logic [7:0]   hold_b    = '0;
    logic [7:0]   hold_g    = '0;

    task automatic note_error(input string msg);
        errs++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    function automatic bit dim_bad(input logic [31:0] v);
        return (v == 32'd0) || (v > DIM_LIMIT);
    endfunction

    // ------------------------------------------------------------------
    // Decoder: one accepted byte in, at most one beat out
    // ------------------------------------------------------------------
    task automatic decode_byte(input logic [7:0] d, input logic first,
                               output bit emit, output bmpp_pkg::result_t r);
        logic [31:0] idx;
        logic [31:0] flip;
        logic [2:0]  err_kind;
        bit          bad;
        bit          px_in;
        emit     = 1'b0;
        r        = '0;
        bad      = 1'b0;
        px_in    = 1'b0;
        err_kind = bmpp_pkg::KIND_PIXEL;

        // file_start restarts from any state
        if (first)
        begin
            ps        = ST_HEADER;
            hdr_idx   = '0;
            hdr_shift = '0;
            col_n     = '0;
            row_n     = '0;
            px_byte   = '0;
            pad_n     = '0;
        end

        case (ps)
            ST_HEADER:
            begin
                hdr_shift = {d, hdr_shift[31:8]};
                idx       = hdr_idx;
                hdr_idx   = hdr_idx + 1;
                // each check fires on the last byte of its field
                if (idx == POS_MAGIC_END && hdr_shift[31:16] != bmpp_pkg::BMP_MAGIC)
                begin
                    bad = 1'b1; err_kind = bmpp_pkg::KIND_BAD_MAGIC;
                end
                else if ((idx == POS_RSVD1_END || idx == POS_RSVD2_END) &&
                         hdr_shift[31:16] != 16'd0)
                begin
                    bad = 1'b1; err_kind = bmpp_pkg::KIND_BAD_RSVD;
                end
                else if (idx == POS_OFFSET_END)
                begin
                    px_offset = hdr_shift;
                    if (hdr_shift < bmpp_pkg::HEADER_BYTES)
                    begin
                        bad = 1'b1; err_kind = bmpp_pkg::KIND_BAD_OFFSET;
                    end
                end
                else if (idx == POS_WIDTH_END)
                begin
                    if (dim_bad(hdr_shift))
                    begin
                        bad = 1'b1; err_kind = bmpp_pkg::KIND_BAD_SIZE;
                    end
                    else
                        img_w = hdr_shift;
                end
                else if (idx == POS_HEIGHT_END)
                begin
                    if (dim_bad(hdr_shift))
                    begin
                        bad = 1'b1; err_kind = bmpp_pkg::KIND_BAD_SIZE;
                    end
                    else
                        img_h = hdr_shift;
                end
                else if (idx == POS_PLANES_END && hdr_shift[31:16] != bmpp_pkg::BMP_PLANES)
                begin
                    bad = 1'b1; err_kind = bmpp_pkg::KIND_BAD_PLANES;
                end
                else if (idx == POS_DEPTH_END)
                begin
                    if (hdr_shift[31:16] != bmpp_pkg::BMP_DEPTH)
                    begin
                        bad = 1'b1; err_kind = bmpp_pkg::KIND_BAD_DEPTH;
                    end
                    else
                        ps = (px_offset == bmpp_pkg::HEADER_BYTES) ? ST_PIXEL : ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (hdr_idx != px_offset)
                    hdr_idx = hdr_idx + 1;
                else
                begin
                    ps    = ST_PIXEL;
                    px_in = 1'b1;
                end
            end
            ST_PIXEL:
                px_in = 1'b1;
            ST_PAD:
            begin
                if (pad_n != 0)
                    pad_n = pad_n - 1;
                if (pad_n == 0)
                    ps = ST_PIXEL;
            end
            default:
                ;   // waiting, or trailing bytes after the image
        endcase

        if (bad)
        begin
            emit   = 1'b1;
            r.kind = err_kind;
            ps     = ST_WAIT;
        end

        // pixel bytes arrive blue, green, red
        if (px_in)
        begin
            if (px_byte == 2'd0)
            begin
                hold_b  = d;
                px_byte = 2'd1;
            end
            else if (px_byte == 2'd1)
            begin
                hold_g  = d;
                px_byte = 2'd2;
            end
            else
            begin
                px_byte      = 2'd0;
                flip         = img_h - 32'd1 - row_n;   // file holds bottom row first
                emit         = 1'b1;
                r.kind       = bmpp_pkg::KIND_PIXEL;
                r.column     = col_n[bmpp_pkg::COORD_W-1:0];
                r.row        = flip[bmpp_pkg::COORD_W-1:0];
                r.red        = d;
                r.green      = hold_g;
                r.blue       = hold_b;
                r.last_pixel = (col_n + 1 == img_w) && (row_n + 1 == img_h);
                col_n        = col_n + 1;
                if (col_n >= img_w)
                begin
                    col_n = '0;
                    row_n = row_n + 1;
                    pad_n = img_w[1:0];
                    if (row_n >= img_h)
                        ps = ST_DONE;
                    else if (pad_n != 0)
                        ps = ST_PAD;
                    else
                        ps = ST_PIXEL;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic push_beat(input logic [7:0] d, input logic first, input bit drain);
        file_byte_t fb;
        fb.data  = d;
        fb.first = first;
        fb.gap   = $urandom_range(0, gap_max);
        fb.drain = drain;
        feed_q.push_back(fb);
    endtask

    function automatic bmp_hdr_t clean_hdr(input logic [31:0] w, input logic [31:0] hh,
                                           input logic [31:0] offs);
        bmp_hdr_t x;
        x.magic  = bmpp_pkg::BMP_MAGIC;
        x.rsvd1  = '0;
        x.rsvd2  = '0;
        x.offset = offs;
        x.width  = w;
        x.height = hh;
        x.planes = bmpp_pkg::BMP_PLANES;
        x.depth  = bmpp_pkg::BMP_DEPTH;
        return x;
    endfunction

    // Header, then skip/pixel/pad bytes when the header is good (random content),
    // optionally cut short (next file restarts mid-stream), then ignored trailing bytes.
    task automatic add_file(input bmp_hdr_t h, input int cut, input int tail, input bit drain);
        logic [239:0] hb;
        longint       body;
        longint       n;
        longint       i;
        logic [7:0]   b;
        bit           ok;
        hb = {h.depth, h.planes, h.height, h.width, INFO_HDR_SIZE, h.offset,
              h.rsvd2, h.rsvd1, 32'($urandom), h.magic};
        ok = (h.magic == bmpp_pkg::BMP_MAGIC) && (h.rsvd1 == 16'd0) && (h.rsvd2 == 16'd0) &&
             (h.offset >= bmpp_pkg::HEADER_BYTES) && !dim_bad(h.width) &&
             !dim_bad(h.height) && (h.planes == bmpp_pkg::BMP_PLANES) &&
             (h.depth == bmpp_pkg::BMP_DEPTH);
        if (ok)
            body = longint'(h.offset) - longint'(bmpp_pkg::HEADER_BYTES) +
                   longint'(h.height) * (3 * longint'(h.width) + longint'(h.width[1:0]));
        else
            body = $urandom_range(0, 8);
        n = longint'(bmpp_pkg::HEADER_BYTES) + body;
        if (cut >= 0 && cut < n)
            n = cut;
        for (i = 0; i < n; i++)
        begin
            b = (i < bmpp_pkg::HEADER_BYTES) ? hb[8*int'(i) +: 8] : 8'($urandom);
            push_beat(b, i == 0, drain && i == 0);
        end
        repeat (tail) push_beat(8'($urandom), 1'b0, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Driver: offers queued bytes, decodes each one on acceptance
    // ------------------------------------------------------------------
    file_byte_t         cur_byte;
    int                 gap_left = 0;
    bit                 offering;
    bit                 has_out;
    bmpp_pkg::result_t  dec_res;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            offering = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                decode_byte(s_axis_tdata, s_axis_tuser[0], has_out, dec_res);
                if (has_out)
                    decoded_q.push_back(dec_res);
                bytes_sent++;
                offering = 1'b0;
                gap_left = (feed_q.size() != 0) ? feed_q[0].gap : 0;
            end
            if (!offering)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (feed_q.size() != 0 &&
                         !(feed_q[0].drain && decoded_q.size() != 0))
                begin
                    cur_byte = feed_q.pop_front();
                    s_axis_tdata <= cur_byte.data;
                    s_axis_tuser <= cur_byte.first;
                    offering = 1'b1;
                end
            end
            // single update per edge: valid stays high across back-to-back beats
            s_axis_tvalid <= offering;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: takes result beats, compares against oldest decoded beat
    // ------------------------------------------------------------------
    bmpp_pkg::result_t  seen_res;
    bmpp_pkg::result_t  want_res;
    int                 rx_wait = 0;
    bit                 rdy;

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            note_error($sformatf("beat %0d %s: got %0h, expected %0h",
                                 beats_seen, name, got, want));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_wait = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen_res.kind       = m_axis_tuser;
                seen_res.column     = m_axis_tdata[11:0];
                seen_res.row        = m_axis_tdata[23:12];
                seen_res.red        = m_axis_tdata[31:24];
                seen_res.green      = m_axis_tdata[39:32];
                seen_res.blue       = m_axis_tdata[47:40];
                seen_res.last_pixel = m_axis_tlast;
                if (decoded_q.size() == 0)
                    note_error($sformatf("beat %0d arrived with nothing expected (kind %0d)",
                                         beats_seen, seen_res.kind));
                else
                begin
                    want_res = decoded_q.pop_front();
                    check_field("kind",   16'(seen_res.kind),       16'(want_res.kind));
                    check_field("column", 16'(seen_res.column),     16'(want_res.column));
                    check_field("row",    16'(seen_res.row),        16'(want_res.row));
                    check_field("red",    16'(seen_res.red),        16'(want_res.red));
                    check_field("green",  16'(seen_res.green),      16'(want_res.green));
                    check_field("blue",   16'(seen_res.blue),       16'(want_res.blue));
                    check_field("last",   16'(seen_res.last_pixel), 16'(want_res.last_pixel));
                end
                beats_seen++;
                rx_wait = rx_lazy ? $urandom_range(0, 3) : 0;
                // switch between stalling and always-ready stretches now and then
                if ($urandom_range(0, 63) == 0)
                    rx_lazy = !rx_lazy;
            end
            if (rx_wait > 0)
            begin
                rx_wait--;
                rdy = 1'b0;
            end
            else
                rdy = !rx_hold;
            m_axis_tready <= rdy;
        end
    end

    // Long back-pressure: sender keeps going, so both parser stages fill and
    // s_axis_tready must drop.
    initial
    begin
        wait (beats_seen >= HOLD_AT_BEAT);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial
    begin : stim
        bmp_hdr_t   hd;
        hdr_fault_t fault;
        int         total;
        int         directed_len;
        int         idle_cycles;
        int         cut;

        // --- directed ---
        gap_max = 0;
        repeat (3) push_beat(8'($urandom), 1'b0, 1'b0);          // no file open yet
        add_file(clean_hdr(2, 2, 54), -1, 2, 1'b0);              // skip gap, 2-byte pad
        add_file(clean_hdr(1, 1, bmpp_pkg::HEADER_BYTES), -1, 3, 1'b0);  // pixels right away
        add_file(clean_hdr(3, 2, bmpp_pkg::HEADER_BYTES), -1, 0, 1'b0);  // 3-byte pad
        add_file(clean_hdr(4, 2, 31), -1, 0, 1'b1);              // no pad, wait for drain

        hd = clean_hdr(2, 2, 54); hd.magic = 16'h4D43;  add_file(hd, -1, 2, 1'b0);
        hd = clean_hdr(2, 2, 54); hd.magic = 16'h4E42;  add_file(hd, -1, 0, 1'b0);
        hd = clean_hdr(2, 2, 54); hd.rsvd1 = 16'h8000;  add_file(hd, -1, 0, 1'b0);
        hd = clean_hdr(2, 2, 54); hd.rsvd2 = 16'h0001;  add_file(hd, -1, 0, 1'b0);
        hd = clean_hdr(2, 2, 29);                       add_file(hd, -1, 0, 1'b0);
        hd = clean_hdr(2, 2, 0);                        add_file(hd, -1, 0, 1'b0);
        hd = clean_hdr(0, 2, 54);                       add_file(hd, -1, 0, 1'b0);
        hd = clean_hdr(DIM_LIMIT + 1, 2, 54);           add_file(hd, -1, 0, 1'b0);
        hd = clean_hdr(32'hFFFF_FFFF, 2, 54);           add_file(hd, -1, 0, 1'b0);
        hd = clean_hdr(2, 0, 54);                       add_file(hd, -1, 0, 1'b0);
        hd = clean_hdr(2, DIM_LIMIT + 1, 54);           add_file(hd, -1, 0, 1'b0);
        hd = clean_hdr(2, 2, 54); hd.planes = 16'd0;    add_file(hd, -1, 0, 1'b0);
        hd = clean_hdr(2, 2, 54); hd.depth = 16'd32;    add_file(hd, -1, 0, 1'b0);
        hd = clean_hdr(2, 2, 54); hd.depth = 16'h0118;  add_file(hd, -1, 0, 1'b0);
        // two faults: the earlier field is the one reported
        hd = clean_hdr(2, 2, 54); hd.rsvd1 = 16'hFFFF; hd.depth = 16'd8;
        add_file(hd, -1, 0, 1'b0);

        // largest sizes, cut short by the next file
        add_file(clean_hdr(DIM_LIMIT, 2, bmpp_pkg::HEADER_BYTES), 30 + 3 * 40, 0, 1'b0);
        add_file(clean_hdr(1, DIM_LIMIT, bmpp_pkg::HEADER_BYTES), 30 + 4 * 10, 0, 1'b0);
        add_file(clean_hdr(2, 2, 32'hFFFF_FFFF), 50, 0, 1'b0);   // skips forever
        add_file(clean_hdr(2, 2, bmpp_pkg::HEADER_BYTES), 12, 0, 1'b0);  // restart in header
        add_file(clean_hdr(3, 2, bmpp_pkg::HEADER_BYTES), 30 + 9 + 1, 0, 1'b0);  // in pad
        add_file(clean_hdr(3, 3, bmpp_pkg::HEADER_BYTES), -1, 4, 1'b0);

        // --- random files: mostly well-formed, some with one bad field ---
        directed_len = feed_q.size();
        while (feed_q.size() < directed_len + RANDOM_BYTES)
        begin
            gap_max = ($urandom_range(0, 2) == 0) ? 0 : 3;
            hd = clean_hdr($urandom_range(1, 5), $urandom_range(1, 4),
                           ($urandom_range(0, 1) == 0) ? bmpp_pkg::HEADER_BYTES
                                                       : $urandom_range(31, 40));
            fault = ($urandom_range(0, 9) < 3) ? hdr_fault_t'($urandom_range(1, 7))
                                               : FLT_NONE;
            case (fault)
                FLT_MAGIC:  hd.magic = 16'($urandom);
                FLT_RSVD:
                begin
                    if ($urandom_range(0, 1) == 0)
                        hd.rsvd1 = 16'($urandom_range(1, 65535));
                    else
                        hd.rsvd2 = 16'($urandom_range(1, 65535));
                end
                FLT_OFFSET: hd.offset = $urandom_range(0, 29);
                FLT_WIDTH:
                begin
                    case ($urandom_range(0, 2))
                        0:       hd.width = '0;
                        1:       hd.width = DIM_LIMIT + 1 + $urandom_range(0, 1000);
                        default: hd.width = {1'b1, 31'($urandom)};
                    endcase
                end
                FLT_HEIGHT:
                begin
                    case ($urandom_range(0, 2))
                        0:       hd.height = '0;
                        1:       hd.height = DIM_LIMIT + 1 + $urandom_range(0, 1000);
                        default: hd.height = {1'b1, 31'($urandom)};
                    endcase
                end
                FLT_PLANES: hd.planes = 16'($urandom_range(2, 65535));
                FLT_DEPTH:  hd.depth = 16'($urandom_range(25, 255));
                default:    ;
            endcase
            cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 60) : -1;
            add_file(hd, cut, $urandom_range(0, 3), $urandom_range(0, 7) == 0);
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 4)) push_beat(8'($urandom), 1'b0, 1'b0);
        end
        total = feed_q.size();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (bytes_sent < total)
            @(posedge clk);
        idle_cycles = 0;
        while (decoded_q.size() != 0 && idle_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            idle_cycles++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (decoded_q.size() != 0)
            note_error($sformatf("%0d expected beats never arrived", decoded_q.size()));

        if (errs == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
